>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/edpc_pkg.sv
// Package with the shared types and constants of the Euler degree parity checker.
`default_nettype none

package edpc_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int VERT_LIM     = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
   localparam int VIDX_W       = 5;
   localparam int CNT_W        = 6;
   localparam int DEG_W        = 6;

   typedef enum logic [1:0] {
      ACT_ADD_EDGE = 2'd0,
      ACT_REPORT   = 2'd1,
      ACT_CIRCUIT  = 2'd2,
      ACT_PATH     = 2'd3
   } action_type;

   typedef enum logic {
      REG_VERTEX_COUNT = 1'b0,
      REG_DIRECTED     = 1'b1
   } csr_index_type;

   typedef logic [VERT_LIM-1:0] row_type;

endpackage

`default_nettype wire

>>> hw/rtl/edpc_degree_unit.sv
// Degree unit: masked row popcount plus the self-loop bit of one vertex.
`default_nettype none

module edpc_degree_unit
   import edpc_pkg::*;
(
   input  row_type              row,
   input  logic [CNT_W-1:0]     count,
   input  logic [VIDX_W-1:0]    vertex,
   output logic [DEG_W-1:0]     degree
);

   row_type          masked;
   logic [DEG_W-1:0] sum;

   always_comb begin
      for (int j = 0; j < VERT_LIM; j++) begin
         masked[j] = row[j] & (CNT_W'(j) < count);
      end
      sum = '0;
      for (int j = 0; j < VERT_LIM; j++) begin
         sum = sum + DEG_W'(masked[j]);
      end
      degree = sum + DEG_W'(masked[vertex]);
   end

endmodule

`default_nettype wire

>>> hw/rtl/euler_degree_parity_checker.sv
// Top level of the Euler degree parity checker: adjacency matrix and scan sequencer.
//
//   Channel   Handshake                 Payload
//   request   start / busy              req_action, req_from_vertex, req_to_vertex
//   result    rsp_valid (one cycle)     rsp_vertex_index, rsp_degree, rsp_verdict,
//                                       rsp_rejected, rsp_last_result
//   csr       csr_valid / csr_ready     csr_index, csr_data
//
// An add edge request does not raise busy; its result shows in the next cycle.
// Report and check requests keep busy high while one shared degree unit reads
// one matrix row per cycle, one row for each of the n active vertices in turn.
// Report results stream one per cycle; a check result follows the last row.
// Reset clears the matrix, sets the vertex count to 1 and clears the directed flag at once; no clearing pass is needed.
// The receiver cannot stall, so results never wait and never hold off a request.
`default_nettype none

module euler_degree_parity_checker
   import edpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [4:0]         req_from_vertex,
   input  logic [4:0]         req_to_vertex,
   output logic               rsp_valid,
   output logic [4:0]         rsp_vertex_index,
   output logic [5:0]         rsp_degree,
   output logic               rsp_verdict,
   output logic               rsp_rejected,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [5:0]         csr_data
);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type         state_ff;
   action_type        act_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [VIDX_W-1:0] idx_ff;
   logic [CNT_W-1:0]  odd_ff;
   logic [CNT_W-1:0]  odd_in;
   logic              last_in;

   logic              rsp_valid_ff;
   logic [4:0]        rsp_vertex_index_ff;
   logic [5:0]        rsp_degree_ff;
   logic              rsp_verdict_ff;
   logic              rsp_rejected_ff;
   logic              rsp_last_result_ff;

   logic [CNT_W-1:0]  vertex_count_ff;
   logic              directed_ff;

   row_type           adj_ff [VERT_LIM];
   row_type           adj_in [VERT_LIM];

   logic [CNT_W-1:0]  n_act;
   logic              go;
   logic              rej_c;
   logic              add_ok;
   logic [DEG_W-1:0]  deg;

   assign busy      = (state_ff == ST_SCAN);
   assign csr_ready = 1'b1;
   assign go        = start && !busy;

   always_comb begin
      if (vertex_count_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (vertex_count_ff > CNT_W'(VERT_LIM)) begin
         n_act = CNT_W'(VERT_LIM);
      end else begin
         n_act = vertex_count_ff;
      end
   end

   assign rej_c  = ({1'b0, req_from_vertex} >= n_act) || ({1'b0, req_to_vertex} >= n_act);
   assign add_ok = go && (action_type'(req_action) == ACT_ADD_EDGE) && !rej_c;

   always_comb begin
      for (int r = 0; r < VERT_LIM; r++) begin
         adj_in[r] = adj_ff[r];
         if (add_ok && (req_from_vertex == VIDX_W'(r))) begin
            adj_in[r][req_to_vertex] = 1'b1;
         end
         if (add_ok && !directed_ff && (req_to_vertex == VIDX_W'(r))) begin
            adj_in[r][req_from_vertex] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < VERT_LIM; r++) begin
         if (reset) begin
            adj_ff[r] <= '0;
         end else begin
            adj_ff[r] <= adj_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= CNT_W'(1);
         directed_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_VERTEX_COUNT: vertex_count_ff <= csr_data;
            REG_DIRECTED:     directed_ff     <= csr_data[0];
            default:          vertex_count_ff <= vertex_count_ff;
         endcase
      end
   end

   edpc_degree_unit u_degree (
      .row    (adj_ff[idx_ff]),
      .count  (n_ff),
      .vertex (idx_ff),
      .degree (deg)
   );

   assign odd_in  = odd_ff + CNT_W'(deg[0]);
   assign last_in = ({1'b0, idx_ff} == (n_ff - CNT_W'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  if (action_type'(req_action) == ACT_ADD_EDGE) begin
                     rsp_valid_ff        <= 1'b1;
                     rsp_vertex_index_ff <= '0;
                     rsp_degree_ff       <= '0;
                     rsp_verdict_ff      <= 1'b0;
                     rsp_rejected_ff     <= rej_c;
                     rsp_last_result_ff  <= 1'b1;
                  end else begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_SCAN;
                     act_ff       <= action_type'(req_action);
                     n_ff         <= n_act;
                     idx_ff       <= '0;
                     odd_ff       <= '0;
                  end
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               odd_ff <= odd_in;
               if (act_ff == ACT_REPORT) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_vertex_index_ff <= idx_ff;
                  rsp_degree_ff       <= deg;
                  rsp_verdict_ff      <= 1'b0;
                  rsp_rejected_ff     <= 1'b0;
                  rsp_last_result_ff  <= last_in;
               end else if (last_in) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_vertex_index_ff <= '0;
                  rsp_degree_ff       <= '0;
                  rsp_rejected_ff     <= 1'b0;
                  rsp_last_result_ff  <= 1'b1;
                  if (act_ff == ACT_CIRCUIT) begin
                     rsp_verdict_ff <= (odd_in == '0);
                  end else begin
                     rsp_verdict_ff <= (odd_in == '0) || (odd_in == CNT_W'(2));
                  end
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
               if (last_in) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + VIDX_W'(1);
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_vertex_index_ff;
   assign rsp_degree       = rsp_degree_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_rejected     = rsp_rejected_ff;
   assign rsp_last_result  = rsp_last_result_ff;

endmodule

`default_nettype wire

>>> hw/rtl/edpc_checker.sv
// Port-level assertion checker for the Euler degree parity checker, with its bind.
`default_nettype none

`include "assert_macros.svh"

module edpc_checker
   import edpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_action,
   input  logic               rsp_valid,
   input  logic [5:0]         rsp_degree,
   input  logic               rsp_verdict,
   input  logic               rsp_rejected,
   input  logic               rsp_last_result
);

   logic add_go;
   logic scan_go;
   logic add_done;
   logic clean_rej;

   assign add_go    = start && !busy && (action_type'(req_action) == ACT_ADD_EDGE);
   assign scan_go   = start && !busy && (action_type'(req_action) != ACT_ADD_EDGE);
   assign add_done  = rsp_valid && rsp_last_result && !busy;
   assign clean_rej = rsp_last_result && (rsp_degree == 6'd0) && !rsp_verdict;

   `ASSERT_NEXT(a_add_answers, clock, reset, add_go, add_done, "add request gave no result")
   `ASSERT_NEXT(a_scan_busy, clock, reset, scan_go, busy && !rsp_valid, "busy did not rise")
   `ASSERT_SAME(a_reject_clean, clock, reset, rsp_valid && rsp_rejected, clean_rej, "bad reject")
   `ASSERT_NEXT(a_stream_solid, clock, reset, rsp_valid && !rsp_last_result, rsp_valid, "gap")

endmodule

bind euler_degree_parity_checker edpc_checker u_edpc_checker (.*);

`default_nettype wire

>>> dv/euler_degree_parity_checker_tb.sv
// Self-checking testbench for the Euler degree parity checker with a built-in degree predictor.
`timescale 1ns / 100ps

module euler_degree_parity_checker_tb;
   import edpc_pkg::*;

   localparam int RANDOM_ITEMS  = 470;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 64;
   localparam int STALL_LIMIT   = 2000;

   typedef struct {
      logic          is_csr;
      csr_index_type reg_idx;
      logic [5:0]    reg_data;
      action_type    act;
      logic [4:0]    from_v;
      logic [4:0]    to_v;
   } stim_op_type;

   typedef struct packed {
      logic [4:0] vertex_index;
      logic [5:0] degree;
      logic       verdict;
      logic       rejected;
      logic       last_result;
   } rsp_fields_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_action = '0;
   logic [4:0] req_from_vertex = '0;
   logic [4:0] req_to_vertex = '0;
   logic       rsp_valid;
   logic [4:0] rsp_vertex_index;
   logic [5:0] rsp_degree;
   logic       rsp_verdict;
   logic       rsp_rejected;
   logic       rsp_last_result;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [5:0] csr_data = '0;

   stim_op_type    pending_ops[$];
   rsp_fields_type expected_results[$];
   int             mismatches = 0;

   logic [31:0] model_rows[32];
   logic [5:0]  model_count;
   logic        model_directed;

   int gap_left, burst_left, settle_cycles, stall_cycles;
   logic req_done, csr_done, drive_start, drive_csr;

   euler_degree_parity_checker DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex), .rsp_valid(rsp_valid),
      .rsp_vertex_index(rsp_vertex_index), .rsp_degree(rsp_degree),
      .rsp_verdict(rsp_verdict), .rsp_rejected(rsp_rejected),
      .rsp_last_result(rsp_last_result), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int vertices_in_use(logic [5:0] count);
      if (count == 0) return 1;
      if (count > VERT_LIM) return VERT_LIM;
      return count;
   endfunction

   function automatic logic [5:0] vertex_degree(int v, int n);
      logic [5:0] d;
      d = '0;
      for (int c = 0; c < n; c++) begin
         if (model_rows[v][c]) d++;
      end
      if (model_rows[v][v]) d++;
      return d;
   endfunction

   task automatic predict_request(input stim_op_type op);
      int n, odd;
      rsp_fields_type r;
      n = vertices_in_use(model_count);
      odd = 0;
      r = '0;
      case (op.act)
         ACT_ADD_EDGE: begin
            if (op.from_v >= n || op.to_v >= n) begin
               r.rejected = 1'b1;
            end else begin
               model_rows[op.from_v][op.to_v] = 1'b1;
               if (!model_directed) model_rows[op.to_v][op.from_v] = 1'b1;
            end
            r.last_result = 1'b1;
            expected_results.push_back(r);
         end
         ACT_REPORT: begin
            for (int i = 0; i < n; i++) begin
               r.vertex_index = 5'(i);
               r.degree = vertex_degree(i, n);
               r.last_result = (i == n - 1);
               expected_results.push_back(r);
            end
         end
         default: begin
            for (int i = 0; i < n; i++) begin
               if (vertex_degree(i, n) % 2 != 0) odd++;
            end
            r.verdict = (op.act == ACT_CIRCUIT) ? (odd == 0) : (odd == 0 || odd == 2);
            r.last_result = 1'b1;
            expected_results.push_back(r);
         end
      endcase
   endtask

   task automatic apply_register(input stim_op_type op);
      if (op.reg_idx == REG_VERTEX_COUNT) model_count = op.reg_data;
      else model_directed = op.reg_data[0];
   endtask

   function automatic void push_csr(csr_index_type idx, logic [5:0] data);
      stim_op_type op;
      op = '{is_csr: 1'b1, reg_idx: idx, reg_data: data, act: ACT_ADD_EDGE,
             from_v: '0, to_v: '0};
      pending_ops.push_back(op);
   endfunction

   function automatic void push_req(action_type act, logic [4:0] f, logic [4:0] t);
      stim_op_type op;
      op = '{is_csr: 1'b0, reg_idx: REG_VERTEX_COUNT, reg_data: '0, act: act,
             from_v: f, to_v: t};
      pending_ops.push_back(op);
   endfunction

   // Driver: requests go out in bursts; register writes wait until the block is quiet.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
         settle_cycles = 0;
         for (int i = 0; i < 32; i++) model_rows[i] = '0;
         model_count = 6'd1;
         model_directed = 1'b0;
      end else begin
         req_done = start && !busy;
         csr_done = csr_valid && csr_ready;
         if (req_done) begin
            predict_request(pending_ops[0]);
            void'(pending_ops.pop_front());
            if (burst_left > 0) burst_left--;
         end
         if (csr_done) begin
            apply_register(pending_ops[0]);
            void'(pending_ops.pop_front());
         end
         if (gap_left > 0) gap_left--;
         if (!start && !busy && !rsp_valid && !csr_valid && expected_results.size() == 0)
            settle_cycles++;
         else
            settle_cycles = 0;

         drive_start = 1'b0;
         drive_csr = 1'b0;
         if (pending_ops.size() != 0) begin
            if (pending_ops[0].is_csr) begin
               if (csr_valid && !csr_done) drive_csr = 1'b1;
               else if (!csr_done && settle_cycles >= SETTLE_CYCLES) drive_csr = 1'b1;
            end else if (start && !req_done) begin
               drive_start = 1'b1;
            end else if (gap_left == 0) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
               if (gap_left == 0) drive_start = 1'b1;
            end
         end

         start <= drive_start;
         csr_valid <= drive_csr;
         if (drive_start) begin
            req_action <= pending_ops[0].act;
            req_from_vertex <= pending_ops[0].from_v;
            req_to_vertex <= pending_ops[0].to_v;
         end
         if (drive_csr) begin
            csr_index <= pending_ops[0].reg_idx;
            csr_data <= pending_ops[0].reg_data;
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: %0d %0d %0b %0b %0b",
                        rsp_vertex_index, rsp_degree, rsp_verdict, rsp_rejected,
                        rsp_last_result);
         end else begin
            if (expected_results[0] !== {rsp_vertex_index, rsp_degree, rsp_verdict,
                                         rsp_rejected, rsp_last_result}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d %0d %0b %0b %0b, got %0d %0d %0b %0b %0b",
                           expected_results[0].vertex_index, expected_results[0].degree,
                           expected_results[0].verdict, expected_results[0].rejected,
                           expected_results[0].last_result, rsp_vertex_index, rsp_degree,
                           rsp_verdict, rsp_rejected, rsp_last_result);
            end
            void'(expected_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else if ((start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int items, phase_len, n, pick;
      logic [5:0] count;
      logic [4:0] f, t;

      push_csr(REG_VERTEX_COUNT, 6'd4);
      push_csr(REG_DIRECTED, 6'd0);
      push_req(ACT_ADD_EDGE, 5'd0, 5'd1);
      push_req(ACT_ADD_EDGE, 5'd1, 5'd2);
      push_req(ACT_ADD_EDGE, 5'd2, 5'd2);
      push_req(ACT_ADD_EDGE, 5'd3, 5'd0);
      push_req(ACT_ADD_EDGE, 5'd4, 5'd0);
      push_req(ACT_ADD_EDGE, 5'd0, 5'd31);
      push_req(ACT_ADD_EDGE, 5'd31, 5'd31);
      push_req(ACT_REPORT, 5'd0, 5'd0);
      push_req(ACT_CIRCUIT, 5'd0, 5'd0);
      push_req(ACT_PATH, 5'd31, 5'd31);
      push_csr(REG_VERTEX_COUNT, 6'd0);
      push_req(ACT_REPORT, 5'd0, 5'd0);
      push_req(ACT_ADD_EDGE, 5'd0, 5'd0);
      push_req(ACT_ADD_EDGE, 5'd1, 5'd0);
      push_req(ACT_CIRCUIT, 5'd0, 5'd0);
      push_csr(REG_VERTEX_COUNT, 6'd63);
      push_csr(REG_DIRECTED, 6'd1);
      push_req(ACT_ADD_EDGE, 5'd31, 5'd0);
      push_req(ACT_ADD_EDGE, 5'd31, 5'd31);
      push_req(ACT_REPORT, 5'd0, 5'd0);
      push_req(ACT_CIRCUIT, 5'd0, 5'd0);
      push_req(ACT_PATH, 5'd0, 5'd0);
      push_csr(REG_VERTEX_COUNT, 6'd2);
      push_req(ACT_REPORT, 5'd0, 5'd0);
      push_req(ACT_CIRCUIT, 5'd0, 5'd0);
      push_req(ACT_PATH, 5'd0, 5'd0);

      items = 0;
      while (items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) count = 6'($urandom_range(1, 4));
         else if (pick < 6) count = 6'($urandom_range(5, 16));
         else if (pick < 9) count = 6'($urandom_range(17, 32));
         else count = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
         push_csr(REG_VERTEX_COUNT, count);
         push_csr(REG_DIRECTED, 6'($urandom_range(0, 63)));
         n = vertices_in_use(count);
         phase_len = $urandom_range(15, 45);
         for (int k = 0; k < phase_len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               if ($urandom_range(0, 9) != 0) begin
                  f = 5'($urandom_range(0, n - 1));
                  t = 5'($urandom_range(0, n - 1));
               end else begin
                  f = 5'($urandom_range(0, 31));
                  t = 5'($urandom_range(0, 31));
               end
               push_req(ACT_ADD_EDGE, f, t);
            end else if (pick < 75) begin
               push_req(ACT_REPORT, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end else if (pick < 88) begin
               push_req(ACT_CIRCUIT, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end else begin
               push_req(ACT_PATH, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end
         end
         items += phase_len;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || expected_results.size() != 0 || start || busy)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> euler_degree_parity_checker.f
+incdir+hw/rtl
hw/rtl/edpc_pkg.sv
hw/rtl/edpc_degree_unit.sv
hw/rtl/euler_degree_parity_checker.sv
hw/rtl/edpc_checker.sv
dv/euler_degree_parity_checker_tb.sv
